[rtl/phase_plane_thruster_control_top_assert.svh]
// Assertion macros shared by the thruster control RTL.
`ifndef PHASE_PLANE_THRUSTER_CONTROL_TOP_ASSERT_SVH
`define PHASE_PLANE_THRUSTER_CONTROL_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ppc_pkg.sv]
// Shared types, codes and widths for the phase-plane thruster controller.
package ppc_pkg;

  localparam int DATA_W  = 32;
  localparam int LIM_W   = 31;
  localparam int WIDE_W  = 52;
  localparam int ICPT_W  = 49;
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = 3;

  typedef enum logic [1:0] {
    RESP_NONE = 2'd0,
    RESP_POS  = 2'd1,
    RESP_NEG  = 2'd2
  } resp_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_OVF    = 2'd2
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_UPPER_RATE = 3'd0,
    REG_LOWER_RATE = 3'd1,
    REG_GRAD_ANGLE = 3'd2,
    REG_HYST_RATE  = 3'd3,
    REG_HYST_ANGLE = 3'd4,
    REG_GRADIENT   = 3'd5,
    REG_BOUND_LOW  = 3'd6,
    REG_BOUND_HIGH = 3'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic [LIM_W-1:0]         RST_UPPER_RATE = 31'd65536;
  localparam logic [LIM_W-1:0]         RST_LOWER_RATE = 31'd32768;
  localparam logic [LIM_W-1:0]         RST_GRAD_ANGLE = 31'd65536;
  localparam logic [LIM_W-1:0]         RST_HYST_RATE  = 31'd49152;
  localparam logic [LIM_W-1:0]         RST_HYST_ANGLE = 31'd32768;
  localparam logic signed [DATA_W-1:0] RST_GRADIENT   = -32'sd98304;
  localparam logic signed [DATA_W-1:0] RST_BOUND_LOW  = -32'sd205887;
  localparam logic signed [DATA_W-1:0] RST_BOUND_HIGH = 32'sd205887;

  // Configuration bundle handed from the register file to the datapath
  typedef struct packed {
    logic        [LIM_W-1:0]  upper_rate;
    logic        [LIM_W-1:0]  lower_rate;
    logic        [LIM_W-1:0]  grad_angle;
    logic        [LIM_W-1:0]  hyst_rate;
    logic        [LIM_W-1:0]  hyst_angle;
    logic signed [DATA_W-1:0] gradient;
    logic signed [DATA_W-1:0] bound_low;
    logic signed [DATA_W-1:0] bound_high;
    logic signed [ICPT_W-1:0] intercept;
  } ppc_cfg_t;

  // Zero-extend a 31-bit limit into the wide signed compare domain
  function automatic logic signed [WIDE_W-1:0] widen_u(input logic [LIM_W-1:0] v);
    widen_u = WIDE_W'($signed({1'b0, v}));
  endfunction

  // True when a wide value does not fit in signed 32 bits
  function automatic logic out_of_32(input logic signed [WIDE_W-1:0] v);
    out_of_32 = !((&v[WIDE_W-1:DATA_W-1]) || !(|v[WIDE_W-1:DATA_W-1]));
  endfunction

endpackage

[rtl/ppc_cfg.sv]
// Configuration register file with the registered hysteresis intercept.
module ppc_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [ppc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [ppc_pkg::DATA_W-1:0]    cfg_data,
  output ppc_pkg::ppc_cfg_t             cfg
);
  import ppc_pkg::*;

  logic        [LIM_W-1:0]  upper_rate;
  logic        [LIM_W-1:0]  lower_rate;
  logic        [LIM_W-1:0]  grad_angle;
  logic        [LIM_W-1:0]  hyst_rate;
  logic        [LIM_W-1:0]  hyst_angle;
  logic signed [DATA_W-1:0] gradient;
  logic signed [DATA_W-1:0] bound_low;
  logic signed [DATA_W-1:0] bound_high;
  logic signed [ICPT_W-1:0] intercept;
  logic signed [2*DATA_W-1:0] slope_prod;
  logic signed [ICPT_W-1:0] intercept_next;

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_rate <= RST_UPPER_RATE;
      lower_rate <= RST_LOWER_RATE;
      grad_angle <= RST_GRAD_ANGLE;
      hyst_rate  <= RST_HYST_RATE;
      hyst_angle <= RST_HYST_ANGLE;
      gradient   <= RST_GRADIENT;
      bound_low  <= RST_BOUND_LOW;
      bound_high <= RST_BOUND_HIGH;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_UPPER_RATE: upper_rate <= cfg_data[LIM_W-1:0];
        REG_LOWER_RATE: lower_rate <= cfg_data[LIM_W-1:0];
        REG_GRAD_ANGLE: grad_angle <= cfg_data[LIM_W-1:0];
        REG_HYST_RATE:  hyst_rate  <= cfg_data[LIM_W-1:0];
        REG_HYST_ANGLE: hyst_angle <= cfg_data[LIM_W-1:0];
        REG_GRADIENT:   gradient   <= $signed(cfg_data);
        REG_BOUND_LOW:  bound_low  <= $signed(cfg_data);
        REG_BOUND_HIGH: bound_high <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Intercept H + floor(S*A / 2^16), recomputed every cycle from the registers
  assign slope_prod     = gradient * $signed({1'b0, hyst_angle});
  assign intercept_next = ICPT_W'($signed({1'b0, hyst_rate}))
                        + ICPT_W'(slope_prod >>> FRAC_W);

  always_ff @(posedge clk) begin
    intercept <= intercept_next;
  end

  always_comb begin
    cfg.upper_rate = upper_rate;
    cfg.lower_rate = lower_rate;
    cfg.grad_angle = grad_angle;
    cfg.hyst_rate  = hyst_rate;
    cfg.hyst_angle = hyst_angle;
    cfg.gradient   = gradient;
    cfg.bound_low  = bound_low;
    cfg.bound_high = bound_high;
    cfg.intercept  = intercept;
  end

endmodule

[rtl/ppc_core.sv]
// Phase-plane decision datapath: critical points, overflow check and firing choice.
module ppc_core (
  input  ppc_pkg::ppc_cfg_t                 cfg,
  input  logic signed [ppc_pkg::DATA_W-1:0] angle_used,
  input  logic signed [ppc_pkg::DATA_W-1:0] rate,
  input  logic                              enabled,
  input  logic                              out_of_bounds,
  input  ppc_pkg::resp_t                    resp_prev,
  output ppc_pkg::resp_t                    resp_next,
  output ppc_pkg::status_t                  status_next
);
  import ppc_pkg::*;

  logic signed [2*DATA_W-1:0] angle_prod;
  logic signed [WIDE_W-1:0] a, r, u, l, g, h, ha, hb, icpt, off;
  logic signed [WIDE_W-1:0] g_lo, g_hi, h_lo, h_hi;
  logic ovf;
  logic fire_neg_idle, fire_pos_idle, fire_pos_hyst, fire_neg_hyst;

  // Offset floor(S*angle / 2^16) and the four critical rates
  assign angle_prod = cfg.gradient * angle_used;
  assign off  = WIDE_W'(angle_prod >>> FRAC_W);
  assign icpt = WIDE_W'(cfg.intercept);
  assign a    = WIDE_W'(angle_used);
  assign r    = WIDE_W'(rate);
  assign u    = widen_u(cfg.upper_rate);
  assign l    = widen_u(cfg.lower_rate);
  assign g    = widen_u(cfg.grad_angle);
  assign h    = widen_u(cfg.hyst_rate);
  assign ha   = widen_u(cfg.hyst_angle);
  assign hb   = g - ha;
  assign g_lo = off - u;
  assign g_hi = off + u;
  assign h_lo = off + icpt;
  assign h_hi = off - icpt;

  assign ovf = out_of_32(icpt) || out_of_32(off) || out_of_32(g_lo) ||
               out_of_32(g_hi) || out_of_32(h_lo) || out_of_32(h_hi);

  // Channel edges while coasting
  assign fire_neg_idle = (a <= 0 && r >= u) || (a >= g && r >= -l) ||
                         (a >= 0 && a <= g && r >= g_hi);
  assign fire_pos_idle = (a >= 0 && r <= -u) || (a <= 0 && a >= -g && r <= g_lo) ||
                         (a <= -g && r <= l);

  // Hysteresis lines while firing
  assign fire_pos_hyst = (a <= -ha && r <= h) || (a <= hb && a >= -ha && r <= h_lo) ||
                         (a >= hb && r <= -u);
  assign fire_neg_hyst = (a <= -hb && r >= u) || (a >= -hb && a <= ha && r >= h_hi) ||
                         (a >= ha && r >= -h);

  // Pick the response and status
  always_comb begin
    resp_next   = RESP_NONE;
    status_next = out_of_bounds ? ST_BOUNDS : ST_OK;
    priority if (!enabled) begin
      resp_next = RESP_NONE;
    end else if (ovf) begin
      resp_next   = RESP_NONE;
      status_next = ST_OVF;
    end else if (resp_prev == RESP_NONE) begin
      if (fire_neg_idle)      resp_next = RESP_NEG;
      else if (fire_pos_idle) resp_next = RESP_POS;
      else                    resp_next = RESP_NONE;
    end else begin
      if (fire_pos_hyst)      resp_next = RESP_POS;
      else if (fire_neg_hyst) resp_next = RESP_NEG;
      else                    resp_next = RESP_NONE;
    end
  end

endmodule

[rtl/phase_plane_thruster_control_top.sv]
// Top level of the phase-plane thruster controller: handshakes, state and result register.
//
// Input channel (in_valid/in_ready) carries angle, rate (signed Q16.16) and enabled.
// Output channel (out_valid/out_ready) returns one response and status per input.
// Configuration channel (cfg_valid/cfg_ready) writes register cfg_index with cfg_data;
// cfg_ready is always high. Write registers only while no item is in flight.
// The input register loads at the input transfer and the result register loads from
// it when the result register is free or drains. Throughput: one item per cycle while
// the receiver keeps out_ready high; the angle product and the decision compares sit
// in the single stage between the two registers, and the intercept product is
// precomputed and registered from the configuration registers in the cycle after a write.
// Reset (rst, synchronous) restores register defaults, clears the held angle and
// the firing state to no fire, and empties both stages.
// When the receiver stalls, the result register holds; one more item can wait in
// the input register, after which in_ready drops until the result is taken.
`include "phase_plane_thruster_control_top_assert.svh"

module phase_plane_thruster_control_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ppc_pkg::DATA_W-1:0] angle,
  input  logic signed [ppc_pkg::DATA_W-1:0] rate,
  input  logic                              enabled,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        response,
  output logic [1:0]                        status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppc_pkg::IDX_W-1:0]         cfg_index,
  input  logic [ppc_pkg::DATA_W-1:0]        cfg_data
);
  import ppc_pkg::*;

  ppc_cfg_t cfg;

  logic                     s1_valid;
  logic signed [DATA_W-1:0] s1_angle;
  logic signed [DATA_W-1:0] s1_rate;
  logic                     s1_enabled;
  logic                     s1_oob;
  logic                     in_oob;
  logic                     advance;

  logic signed [DATA_W-1:0] held_angle;
  resp_t                    current_response;
  logic signed [DATA_W-1:0] angle_used;
  resp_t                    resp_prev;
  resp_t                    resp_next;
  status_t                  status_next;

  assign cfg_ready = 1'b1;

  ppc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: the input stage moves when the result register is free or drains
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign in_oob   = (angle < cfg.bound_low) || (angle >= cfg.bound_high);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_angle   <= angle;
      s1_rate    <= rate;
      s1_enabled <= enabled;
      s1_oob     <= in_oob;
    end
  end

  // Out-of-bounds angle keeps the held angle and forces no fire first
  assign angle_used = s1_oob ? held_angle : s1_angle;
  assign resp_prev  = s1_oob ? RESP_NONE : current_response;

  ppc_core u_core (
    .cfg           (cfg),
    .angle_used    (angle_used),
    .rate          (s1_rate),
    .enabled       (s1_enabled),
    .out_of_bounds (s1_oob),
    .resp_prev     (resp_prev),
    .resp_next     (resp_next),
    .status_next   (status_next)
  );

  // Advance controller state on each processed transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      held_angle       <= '0;
      current_response <= RESP_NONE;
    end else if (s1_valid && advance) begin
      current_response <= resp_next;
      if (!s1_oob) begin
        held_angle <= s1_angle;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      response <= resp_next;
      status   <= status_next;
    end
  end

  `PPC_ASSERT_NOW(a_resp_code, out_valid, response != 2'd3, "illegal response code")
  `PPC_ASSERT_NOW(a_ovf_no_fire, out_valid && status == ST_OVF, response == RESP_NONE, "overflow must not fire")
  `PPC_ASSERT_NEXT(a_safed_state, s1_valid && advance && !s1_enabled, current_response == RESP_NONE, "disabled item left firing state")
  `PPC_ASSERT_NEXT(a_drain, out_valid && out_ready && !s1_valid, !out_valid, "result repeated after transfer")

endmodule
